// File: rtl/sogt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the slot ownership guard table.
package sogt_pkg;

  localparam logic [15:0] NO_SHARD = 16'hFFFF;

  localparam logic [2:0] SLOT_UNOWNED = 3'd0;
  localparam logic [2:0] SLOT_STABLE  = 3'd1;
  localparam logic [2:0] SLOT_FENCED  = 3'd2;
  localparam logic [2:0] SLOT_ASK     = 3'd3;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  typedef enum logic [3:0] {
    ERR_OK             = 4'd0,
    ERR_RANGE          = 4'd1,
    ERR_CAS            = 4'd2,
    ERR_UNOWNED_ACTIVE = 4'd3,
    ERR_OWNED_INVALID  = 4'd4,
    ERR_BACKWARDS      = 4'd5,
    ERR_OWNER_CHANGE   = 4'd6,
    ERR_FENCED_REOPEN  = 4'd7,
    ERR_MISMATCH       = 4'd8,
    ERR_FENCED         = 4'd9,
    ERR_NEEDS_ASKING   = 4'd10,
    ERR_NOT_WRITABLE   = 4'd11
  } err_t;

  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_EVAL  = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [63:0] epoch;
    logic [2:0]  status;
  } entry_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] slot_index;
    logic [63:0] cas_epoch;
    logic [15:0] owner_shard;
    logic [63:0] owner_epoch;
    logic [2:0]  owner_state;
    logic        asking;
  } req_t;

endpackage

// File: rtl/slot_ownership_guard_table_unit.sv
`timescale 1ns / 1ps
// Top level of the slot ownership guard table: entry memory, control and result register.
// The table holds owner shard, epoch and state for each of SLOT_COUNT slots in one
// synchronous memory. After reset the block sweeps the memory once, writing the
// no-owner entry into every slot, one slot per cycle, while in_stall stays high.
// Afterwards the entry for each request is read at
// the edge that accepts the word, and the rules are evaluated on the registered read
// data in the evaluation state, where an allowed update is written back and the result word
// is loaded into the output register. A new request word is taken while a finished
// result still waits in the output register; evaluation of that request holds until
// the output register frees up. Every request, refused or not, yields exactly one
// result word.
module slot_ownership_guard_table_unit
  import sogt_pkg::*;
#(
  parameter int SLOT_COUNT = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_slot_index,
  input  logic [63:0] in_cas_epoch,
  input  logic [15:0] in_owner_shard,
  input  logic [63:0] in_owner_epoch,
  input  logic [2:0]  in_owner_state,
  input  logic        in_asking,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [3:0]  out_error_code
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  fsm_t            state_r, state_nxt;
  logic [AW-1:0]   clr_idx_r, clr_idx_nxt;
  req_t            req_r;
  entry_t          rd_entry_r;
  entry_t          mem [SLOT_COUNT];

  logic            in_take;
  logic            finish;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  entry_t          mem_wd;
  logic            slot_ok;
  err_t            code;

  logic            out_valid_r, out_valid_nxt;
  logic            out_accepted_r;
  err_t            out_error_code_r;

  assign in_take = in_valid && !in_stall;
  assign slot_ok = {1'b0, req_r.slot_index} < 17'(SLOT_COUNT);

  sogt_rules u_rules (
    .req     (req_r),
    .cur     (rd_entry_r),
    .slot_ok (slot_ok),
    .code    (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FSM_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Sequencer: sweep after reset, then accept, evaluate, retire.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    in_stall    = 1'b1;
    finish      = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = req_r.slot_index[AW-1:0];
    mem_wd      = '{owner: req_r.owner_shard, epoch: req_r.owner_epoch,
                    status: req_r.owner_state};
    case (state_r)
      FSM_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        mem_wd      = '{owner: NO_SHARD, epoch: 64'd0, status: SLOT_UNOWNED};
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(SLOT_COUNT - 1)) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        // hold until the output register can take the result
        if (!out_valid_r || !out_stall) begin
          finish    = 1'b1;
          mem_we    = (req_r.req_type == REQ_UPDATE) && (code == ERR_OK);
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_CLEAR;
      end
    endcase
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_take) begin
      rd_entry_r <= mem[in_slot_index[AW-1:0]];
    end
  end

  // Capture the request word.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= '{req_type: in_req_type, slot_index: in_slot_index,
                 cas_epoch: in_cas_epoch, owner_shard: in_owner_shard,
                 owner_epoch: in_owner_epoch, owner_state: in_owner_state,
                 asking: in_asking};
    end
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_accepted_r   <= (code == ERR_OK);
      out_error_code_r <= code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_error_code = out_error_code_r;

  // No request word may enter while the sweep runs or a request is in flight.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_CLEAR || state_r == FSM_EVAL) |-> in_stall)
    else $error("request accepted while busy");

  // Table only changes during the sweep or when an update retires.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == FSM_CLEAR || (finish && req_r.req_type == REQ_UPDATE)))
    else $error("unexpected table write");

  // A new result appears only right after an evaluation cycle.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == FSM_EVAL))
    else $error("result without request");

  // The accepted flag agrees with the code.
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_accepted_r == (out_error_code_r == ERR_OK)))
    else $error("accepted flag disagrees with error code");

endmodule

// File: rtl/sogt_rules.sv
`timescale 1ns / 1ps
// Rule evaluation for one request against the current slot entry.
module sogt_rules
  import sogt_pkg::*;
(
  input  req_t   req,
  input  entry_t cur,
  input  logic   slot_ok,
  output err_t   code
);

  logic ep_lt;
  logic ep_eq;

  assign ep_lt = req.owner_epoch < cur.epoch;
  assign ep_eq = req.owner_epoch == cur.epoch;

  always_comb begin
    code = ERR_OK;
    if (!slot_ok) begin
      code = ERR_RANGE;
    end else if (req.req_type == REQ_UPDATE) begin
      if (cur.epoch != req.cas_epoch) begin
        code = ERR_CAS;
      end else if (req.owner_shard == NO_SHARD && req.owner_state != SLOT_UNOWNED) begin
        code = ERR_UNOWNED_ACTIVE;
      end else if (req.owner_shard != NO_SHARD &&
                   (req.owner_epoch == 64'd0 || req.owner_state == SLOT_UNOWNED)) begin
        code = ERR_OWNED_INVALID;
      end else if (ep_lt) begin
        code = ERR_BACKWARDS;
      end else if (cur.owner != NO_SHARD && req.owner_shard != NO_SHARD &&
                   req.owner_shard != cur.owner && (ep_lt || ep_eq)) begin
        code = ERR_OWNER_CHANGE;
      end else if (cur.status == SLOT_FENCED && req.owner_shard == cur.owner && ep_eq &&
                   req.owner_state == SLOT_STABLE) begin
        code = ERR_FENCED_REOPEN;
      end
    end else begin
      // write check: identity first, then state rules
      if (cur.owner != req.owner_shard || !ep_eq) begin
        code = ERR_MISMATCH;
      end else if (cur.status == SLOT_FENCED) begin
        code = ERR_FENCED;
      end else if (cur.status == SLOT_ASK && !req.asking) begin
        code = ERR_NEEDS_ASKING;
      end else if (!(cur.status inside {SLOT_STABLE, SLOT_ASK})) begin
        code = ERR_NOT_WRITABLE;
      end
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slot ownership guard table unit.
module tb_top
  import sogt_pkg::*;
();

  localparam int SLOT_COUNT = 16384;
  localparam int RANDOM_WORDS = 576;
  // Second drain point, well inside the random part.
  localparam int DRAIN_AT = 450;
  // Window of words with no idling on either side.
  localparam int CALM_LO = 250;
  localparam int CALM_HI = 400;
  localparam int TAIL_CYCLES = 16;
  // Clearing sweep plus the time for every word, many times over.
  localparam int CYCLE_LIMIT = 250000;

  localparam entry_t ENTRY_RESET = {NO_SHARD, 64'd0, SLOT_UNOWNED};

  typedef struct packed {
    logic ok;
    err_t code;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [15:0] in_slot_index = '0;
  logic [63:0] in_cas_epoch = '0;
  logic [15:0] in_owner_shard = '0;
  logic [63:0] in_owner_epoch = '0;
  logic [2:0]  in_owner_state = '0;
  logic        in_asking = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [3:0]  out_error_code;

  // Words waiting to be sent, and the verdicts still owed by the block.
  req_t     req_q[$];
  verdict_t verdict_q[$];

  // Slot table as the stimulus plans it, and as the accepted words leave it.
  entry_t plan_tbl[SLOT_COUNT];
  entry_t live_tbl[SLOT_COUNT];

  int   directed_n = 0;
  int   issued = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   cycles = 0;
  logic drained = 1'b1;

  slot_ownership_guard_table_unit #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_slot_index    (in_slot_index),
    .in_cas_epoch     (in_cas_epoch),
    .in_owner_shard   (in_owner_shard),
    .in_owner_epoch   (in_owner_epoch),
    .in_owner_state   (in_owner_state),
    .in_asking        (in_asking),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Judge one request against the current entry; hand back the entry as it stands
  // afterwards. Refused requests leave the entry untouched.
  function automatic err_t slot_rule(input req_t r, input entry_t cur, output entry_t nxt);
    nxt = cur;
    if (r.slot_index >= SLOT_COUNT) return ERR_RANGE;
    if (r.req_type == REQ_CHECK) begin
      if (cur.owner != r.owner_shard || cur.epoch != r.owner_epoch) return ERR_MISMATCH;
      if (cur.status == SLOT_FENCED) return ERR_FENCED;
      if (cur.status == SLOT_ASK && !r.asking) return ERR_NEEDS_ASKING;
      if (cur.status != SLOT_STABLE && cur.status != SLOT_ASK) return ERR_NOT_WRITABLE;
      return ERR_OK;
    end
    // Guarded update: compare-and-swap on the epoch, then the consistency rules in order.
    if (cur.epoch != r.cas_epoch) return ERR_CAS;
    if (r.owner_shard == NO_SHARD) begin
      if (r.owner_state != SLOT_UNOWNED) return ERR_UNOWNED_ACTIVE;
    end else if (r.owner_epoch == 64'd0 || r.owner_state == SLOT_UNOWNED) begin
      return ERR_OWNED_INVALID;
    end
    if (r.owner_epoch < cur.epoch) return ERR_BACKWARDS;
    if (cur.owner != NO_SHARD && r.owner_shard != NO_SHARD && r.owner_shard != cur.owner
        && r.owner_epoch <= cur.epoch) return ERR_OWNER_CHANGE;
    if (cur.status == SLOT_FENCED && r.owner_shard == cur.owner
        && r.owner_epoch == cur.epoch && r.owner_state == SLOT_STABLE) return ERR_FENCED_REOPEN;
    nxt = {r.owner_shard, r.owner_epoch, r.owner_state};
    return ERR_OK;
  endfunction

  function automatic req_t mk_req(input logic kind, input logic [15:0] slot,
                                  input logic [63:0] exp_ep, input logic [15:0] shard,
                                  input logic [63:0] ep, input logic [2:0] st,
                                  input logic ask);
    return {kind, slot, exp_ep, shard, ep, st, ask};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly a handful of busy slots so that sequences build up history on them.
  function automatic logic [15:0] pick_slot();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return 16'(SLOT_COUNT - 1 - $urandom_range(1));
    if (roll < 75) return 16'($urandom_range(3));
    if (roll < 95) return 16'($urandom_range(SLOT_COUNT - 1));
    return 16'($urandom_range(65535, SLOT_COUNT));
  endfunction

  function automatic logic [63:0] next_epoch(input logic [63:0] cur);
    case ($urandom_range(9))
      0, 1, 2: return cur;
      3, 4, 5, 6: return cur + 64'($urandom_range(3, 1));
      7: return cur - 64'd1;
      8: return rand64();
      default: return 64'd0;
    endcase
  endfunction

  // Queue a word and advance the planned table so later words can follow the entry.
  task automatic enqueue_word(input req_t r);
    entry_t cur;
    entry_t nxt;
    cur = (r.slot_index < SLOT_COUNT) ? plan_tbl[r.slot_index] : ENTRY_RESET;
    void'(slot_rule(r, cur, nxt));
    if (r.slot_index < SLOT_COUNT) plan_tbl[r.slot_index] = nxt;
    req_q.insert(req_q.size(), r);
  endtask

  task automatic fill_directed();
    logic [15:0] s;
    logic [15:0] top;
    s = 16'd5;
    top = 16'(SLOT_COUNT - 1);
    // Out of range for both kinds, at the first bad index and at the largest.
    enqueue_word(mk_req(REQ_CHECK, 16'(SLOT_COUNT), '0, NO_SHARD, '0, SLOT_UNOWNED, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, 16'hFFFF, '0, 16'd1, 64'd1, SLOT_STABLE, 1'b0));
    // Fresh slot: owner and epoch match the reset entry but it is not writable.
    enqueue_word(mk_req(REQ_CHECK, s, '0, NO_SHARD, '0, SLOT_UNOWNED, 1'b1));
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd1, 16'd3, 64'd4, SLOT_STABLE, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, s, '0, NO_SHARD, 64'd4, SLOT_STABLE, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, s, '0, 16'd3, 64'd0, SLOT_STABLE, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, s, '0, 16'd3, 64'd5, SLOT_UNOWNED, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, s, '0, 16'd3, 64'd10, SLOT_STABLE, 1'b0));
    // Epoch going backwards, then an owner change at the same epoch.
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd10, 16'd3, 64'd9, SLOT_STABLE, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd10, 16'd4, 64'd10, SLOT_STABLE, 1'b0));
    // Fence the source, then try to reopen it at the same epoch.
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd10, 16'd3, 64'd10, SLOT_FENCED, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd10, 16'd3, 64'd10, SLOT_STABLE, 1'b0));
    enqueue_word(mk_req(REQ_CHECK, s, '0, 16'd3, 64'd10, SLOT_UNOWNED, 1'b1));
    enqueue_word(mk_req(REQ_CHECK, s, '0, 16'd4, 64'd10, SLOT_UNOWNED, 1'b1));
    // Hand over to the target in ask state; checks with and without the flag.
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd10, 16'd4, 64'd11, SLOT_ASK, 1'b0));
    enqueue_word(mk_req(REQ_CHECK, s, '0, 16'd4, 64'd11, SLOT_UNOWNED, 1'b0));
    enqueue_word(mk_req(REQ_CHECK, s, '0, 16'd4, 64'd11, SLOT_UNOWNED, 1'b1));
    // One of the other states is stored but does not allow writes.
    enqueue_word(mk_req(REQ_UPDATE, s, 64'd11, 16'd4, 64'd12, 3'd5, 1'b0));
    enqueue_word(mk_req(REQ_CHECK, s, '0, 16'd4, 64'd12, SLOT_UNOWNED, 1'b1));
    // Last slot with the widest values, then release it.
    enqueue_word(mk_req(REQ_UPDATE, top, '0, 16'hFFFE, '1, 3'd7, 1'b1));
    enqueue_word(mk_req(REQ_CHECK, top, '1, 16'hFFFE, '1, 3'd7, 1'b1));
    enqueue_word(mk_req(REQ_UPDATE, top, '1, NO_SHARD, '1, SLOT_UNOWNED, 1'b0));
    enqueue_word(mk_req(REQ_UPDATE, 16'd0, '0, 16'd0, 64'd1, SLOT_STABLE, 1'b0));
    enqueue_word(mk_req(REQ_CHECK, 16'd0, '0, 16'd0, 64'd1, SLOT_UNOWNED, 1'b0));
  endtask

  task automatic fill_random(input int n);
    entry_t      cur;
    logic [15:0] s;
    logic [15:0] shard;
    logic [63:0] ep;
    logic [63:0] exp_ep;
    logic [2:0]  st;
    int          roll;
    for (int i = 0; i < n; i++) begin
      s = pick_slot();
      cur = (s < SLOT_COUNT) ? plan_tbl[s] : ENTRY_RESET;
      roll = $urandom_range(99);
      if (roll < 40) begin
        // Update built against the planned entry, with the epoch mostly right.
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: shard = (cur.owner == NO_SHARD) ? 16'($urandom_range(7))
                                                              : cur.owner;
          6, 7: shard = 16'($urandom_range(7));
          8: shard = NO_SHARD;
          default: shard = 16'($urandom);
        endcase
        if (shard == NO_SHARD) begin
          st = ($urandom_range(4) == 0) ? 3'($urandom) : SLOT_UNOWNED;
        end else begin
          case ($urandom_range(9))
            0, 1, 2, 3: st = SLOT_STABLE;
            4, 5: st = SLOT_FENCED;
            6, 7: st = SLOT_ASK;
            8: st = 3'($urandom_range(7, 4));
            default: st = SLOT_UNOWNED;
          endcase
        end
        ep = next_epoch(cur.epoch);
        exp_ep = ($urandom_range(9) == 0) ? cur.epoch ^ (64'd1 << $urandom_range(63))
                                          : cur.epoch;
        enqueue_word(mk_req(REQ_UPDATE, s, exp_ep, shard, ep, st, 1'($urandom)));
      end else if (roll < 75) begin
        // Check, mostly from the rightful owner at the current epoch.
        shard = ($urandom_range(4) != 0) ? cur.owner : 16'($urandom_range(7));
        ep = ($urandom_range(4) != 0) ? cur.epoch : next_epoch(cur.epoch);
        enqueue_word(mk_req(REQ_CHECK, s, rand64(), shard, ep, 3'($urandom), 1'($urandom)));
      end else begin
        // Noise: every field random.
        if ($urandom_range(1) == 0) s = 16'($urandom);
        enqueue_word(mk_req(1'($urandom), s, rand64(), 16'($urandom), rand64(),
                            3'($urandom), 1'($urandom)));
      end
    end
  endtask

  // Build the stimulus, release reset, then wait for the block to drain.
  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      plan_tbl[i] = ENTRY_RESET;
      live_tbl[i] = ENTRY_RESET;
    end
    fill_directed();
    directed_n = req_q.size();
    fill_random(RANDOM_WORDS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Sample on the falling edge so the queues are settled for this cycle.
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Driver: hold a stalled word, otherwise send the next one unless idling or draining.
  // Drain fully after the directed words and once more in the random part.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (req_q.size() == 0
          || ((issued == directed_n || issued == DRAIN_AT) && (!drained || in_valid))
          || (!(issued >= CALM_LO && issued < CALM_HI) && $urandom_range(99) < 8)) begin
        in_valid <= 1'b0;
      end else begin
        {in_req_type, in_slot_index, in_cas_epoch, in_owner_shard, in_owner_epoch,
         in_owner_state, in_asking} <= req_q.pop_front();
        in_valid <= 1'b1;
        issued++;
      end
    end
  end

  // Monitor: retire the result word first, then predict the word taken at this edge,
  // so a word can never match its own verdict. Stall the result side at random.
  always @(posedge clk) begin
    verdict_t v;
    entry_t   cur;
    entry_t   nxt;
    req_t     r;
    err_t     code;
    if (!rst_n) begin
      out_stall <= 1'b0;
      drained <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected: accepted %0d code %0d",
                   $time, out_accepted, out_error_code);
        end else begin
          v = verdict_q.pop_front();
          if (out_accepted !== v.ok) begin
            errors++;
            $display("%0t: accepted mismatch: expected %0d actual %0d",
                     $time, v.ok, out_accepted);
          end
          if (out_error_code !== v.code) begin
            errors++;
            $display("%0t: error_code mismatch: expected %0d actual %0d",
                     $time, v.code, out_error_code);
          end
        end
      end
      if (in_valid && !in_stall) begin
        r = {in_req_type, in_slot_index, in_cas_epoch, in_owner_shard, in_owner_epoch,
             in_owner_state, in_asking};
        cur = (r.slot_index < SLOT_COUNT) ? live_tbl[r.slot_index] : ENTRY_RESET;
        code = slot_rule(r, cur, nxt);
        if (r.slot_index < SLOT_COUNT) live_tbl[r.slot_index] = nxt;
        v = {code == ERR_OK, code};
        verdict_q.insert(verdict_q.size(), v);
      end
      drained <= (verdict_q.size() == 0);
      out_stall <= !(results_seen >= CALM_LO && results_seen < CALM_HI)
                   && $urandom_range(99) < 8;
    end
  end

  // Watchdog: a hung block must not hang the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
